// ===== hdl/u8v_pkg.sv =====
package u8v_pkg;

  localparam int COUNT_BITS_DEFAULT = 24;
  localparam int OUT_CNT_W = 24;
  localparam int CP_W = 21;

  // lead byte ranges
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG = 8'h80;

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_2B = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3B = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4B = 21'h010000;

  localparam logic [CP_W-1:0] CP_CR = 21'h00000D;
  localparam logic [CP_W-1:0] CP_LF = 21'h00000A;

  // sequence class codes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_2B = 2'd1;
  localparam logic [1:0] CLS_3B = 2'd2;
  localparam logic [1:0] CLS_4B = 2'd3;

  typedef struct packed {
    logic                 done;
    logic [CP_W-1:0]      value;
    logic                 err;
    logic [OUT_CNT_W-1:0] err_offset;
    logic [OUT_CNT_W-1:0] err_line;
    logic [OUT_CNT_W-1:0] err_column;
    logic                 last;
    logic                 valid;
  } result_t;

  function automatic logic [CP_W-1:0] min_for_class(input logic [1:0] cls);
    logic [CP_W-1:0] m;
    case (cls)
      CLS_2B: m = MIN_2B;
      CLS_3B: m = MIN_3B;
      CLS_4B: m = MIN_4B;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/u8v_core.sv =====
module u8v_core #(
  parameter int COUNT_BITS = u8v_pkg::COUNT_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [7:0]       data_byte,
  input  logic             byte_present,
  input  logic             end_of_source,
  output u8v_pkg::result_t res
);
  import u8v_pkg::*;

  logic [1:0]            bytes_remaining, bytes_remaining_next;
  logic [CP_W-1:0]       partial_value, partial_value_next;
  logic [1:0]            overlong_class, overlong_class_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [COUNT_BITS-1:0] lead_position, lead_position_next;
  logic [COUNT_BITS-1:0] line_count, line_count_next;
  logic [COUNT_BITS-1:0] column_count, column_count_next;
  logic                  after_cr, after_cr_next;
  logic                  error_seen, error_seen_next;

  logic                  fail;
  logic                  done;
  logic [CP_W-1:0]       cp;
  logic [CP_W-1:0]       shifted;
  logic [COUNT_BITS-1:0] at;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+OUT_CNT_W-1:0] w;
    w = {{OUT_CNT_W{1'b0}}, v};
    return w[OUT_CNT_W-1:0];
  endfunction

  assign shifted = {partial_value[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    partial_value_next   = partial_value;
    overlong_class_next  = overlong_class;
    byte_count_next      = byte_count;
    lead_position_next   = lead_position;
    line_count_next      = line_count;
    column_count_next    = column_count;
    after_cr_next        = after_cr;
    error_seen_next      = error_seen;
    fail = 1'b0;
    done = 1'b0;
    cp   = '0;
    at   = byte_count;
    res  = '0;

    if (byte_present && !error_seen) begin
      if (bytes_remaining == 2'd0) begin
        if (data_byte < CONT_TAG) begin
          cp   = {13'd0, data_byte};
          done = 1'b1;
        end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
          bytes_remaining_next = 2'd1;
          partial_value_next   = {16'd0, data_byte[4:0]};
          overlong_class_next  = CLS_2B;
          lead_position_next   = byte_count;
        end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
          bytes_remaining_next = 2'd2;
          partial_value_next   = {17'd0, data_byte[3:0]};
          overlong_class_next  = CLS_3B;
          lead_position_next   = byte_count;
        end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
          bytes_remaining_next = 2'd3;
          partial_value_next   = {18'd0, data_byte[2:0]};
          overlong_class_next  = CLS_4B;
          lead_position_next   = byte_count;
        end else begin
          fail = 1'b1;
        end
      end else begin
        at = lead_position;
        if ((data_byte & CONT_MASK) != CONT_TAG) begin
          fail = 1'b1;
        end else begin
          partial_value_next   = shifted;
          bytes_remaining_next = bytes_remaining - 2'd1;
          if (bytes_remaining == 2'd1) begin
            if (shifted < min_for_class(overlong_class) || shifted > CP_MAX ||
                (shifted >= SURR_LO && shifted <= SURR_HI)) begin
              fail = 1'b1;
            end else begin
              cp   = shifted;
              done = 1'b1;
            end
          end
        end
      end

      if (fail) begin
        res.err              = 1'b1;
        res.err_offset       = to_out(at);
        res.err_line         = to_out(line_count);
        res.err_column       = to_out(column_count);
        error_seen_next      = 1'b1;
        bytes_remaining_next = 2'd0;
        partial_value_next   = '0;
        overlong_class_next  = CLS_NONE;
      end else if (done) begin
        partial_value_next  = '0;
        overlong_class_next = CLS_NONE;
        if (cp == CP_CR) begin
          line_count_next   = sat_inc(line_count);
          column_count_next = {{(COUNT_BITS-1){1'b0}}, 1'b1};
          after_cr_next     = 1'b1;
        end else if (cp == CP_LF) begin
          if (!after_cr) begin
            line_count_next   = sat_inc(line_count);
            column_count_next = {{(COUNT_BITS-1){1'b0}}, 1'b1};
          end
          after_cr_next = 1'b0;
        end else begin
          column_count_next = sat_inc(column_count);
          after_cr_next     = 1'b0;
        end
      end
    end

    if (byte_present) begin
      byte_count_next = sat_inc(byte_count);
    end

    res.done  = done;
    res.value = cp;
    res.last  = end_of_source;

    if (end_of_source) begin
      // sequence cut off by the end marker
      if (!error_seen_next && bytes_remaining_next != 2'd0) begin
        res.err         = 1'b1;
        res.err_offset  = to_out(lead_position_next);
        res.err_line    = to_out(line_count_next);
        res.err_column  = to_out(column_count_next);
        error_seen_next = 1'b1;
      end
      res.valid            = !error_seen_next;
      bytes_remaining_next = 2'd0;
      partial_value_next   = '0;
      overlong_class_next  = CLS_NONE;
      byte_count_next      = '0;
      lead_position_next   = '0;
      line_count_next      = {{(COUNT_BITS-1){1'b0}}, 1'b1};
      column_count_next    = {{(COUNT_BITS-1){1'b0}}, 1'b1};
      after_cr_next        = 1'b0;
      error_seen_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      partial_value   <= '0;
      overlong_class  <= CLS_NONE;
      byte_count      <= '0;
      lead_position   <= '0;
      line_count      <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
      column_count    <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
      after_cr        <= 1'b0;
      error_seen      <= 1'b0;
    end else if (en) begin
      bytes_remaining <= bytes_remaining_next;
      partial_value   <= partial_value_next;
      overlong_class  <= overlong_class_next;
      byte_count      <= byte_count_next;
      lead_position   <= lead_position_next;
      line_count      <= line_count_next;
      column_count    <= column_count_next;
      after_cr        <= after_cr_next;
      error_seen      <= error_seen_next;
    end
  end

  a_no_open_seq_after_error: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> bytes_remaining == 2'd0)
    else $error("sequence still open after error");

  a_class_tracks_remaining: assert property (@(posedge clk) disable iff (rst)
    (bytes_remaining == 2'd0) == (overlong_class == CLS_NONE))
    else $error("sequence class out of step with remaining count");

  a_error_latches: assert property (@(posedge clk) disable iff (rst)
    (en && res.err && !end_of_source) |=> error_seen)
    else $error("error not latched");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (en && end_of_source) |=> (!error_seen && bytes_remaining == 2'd0 &&
                               byte_count == '0))
    else $error("end marker did not restart the source");

endmodule

// ===== hdl/utf8_validator_with_location.sv =====
// channel  dir  tdata                                    tuser                     tlast
// s_axis   in   [7:0] data_byte                          [0] byte_present          end_of_source
// m_axis   out  [20:0] codepoint_value, [44:21] offset,  [0] codepoint_done,       source_end
//               [68:45] line, [92:69] column, [93] valid [1] error_found
//
// one item per clock sustained while the output is not stalled; each item goes
// through the input register, then the result register
// the decode and counter update sit in one combinational stage between them
// rst is synchronous and clears the counters, sequence state and both valids
// a stalled output holds the result register; the input register keeps
// taking items until it is also full
module utf8_validator_with_location #(
  parameter int COUNT_BITS = u8v_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // codepoint_value, error_offset, error_line,
                                     // error_column, source_valid, zero fill
  output logic [1:0]  m_axis_tuser,  // codepoint_done, error_found
  output logic        m_axis_tlast
);
  import u8v_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_present;
  logic       in_last;
  logic       out_valid;
  logic       out_free;
  logic       fire;
  result_t    res;
  result_t    out_res;

  assign out_free      = !out_valid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte    <= s_axis_tdata;
      in_present <= s_axis_tuser;
      in_last    <= s_axis_tlast;
    end
  end

  u8v_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .en            (fire),
    .data_byte     (in_byte),
    .byte_present  (in_present),
    .end_of_source (in_last),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.valid, out_res.err_column, out_res.err_line,
                          out_res.err_offset, out_res.value};
  assign m_axis_tuser  = {out_res.err, out_res.done};
  assign m_axis_tlast  = out_res.last;

  a_no_loss_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while stalled");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !fire) |=> (in_valid && $stable(in_byte) && $stable(in_last)))
    else $error("input register lost an item");

  a_done_excludes_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("codepoint and error on the same item");

endmodule
